/* hdl/bsd_pkg.sv */
// Shared constants and result type for the BMP stream decoder.
package bsd_pkg;

    localparam int DIM_W       = 15;
    localparam int ROW_BYTES_W = 17;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_TRUNCATED   = 3'd1;
    localparam logic [2:0] ERR_BAD_MAGIC   = 3'd2;
    localparam logic [2:0] ERR_UNSUPPORTED = 3'd3;
    localparam logic [2:0] ERR_BAD_DIMS    = 3'd4;

    localparam logic [DIM_W-1:0] MAX_DIM_RESET = 15'd20000;

    typedef struct packed {
        logic [1:0]       result_kind;
        logic [2:0]       error_code;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [DIM_W-1:0] out_row;
        logic [DIM_W-1:0] out_column;
        logic [DIM_W-1:0] image_width;
        logic [DIM_W-1:0] image_height;
        logic             last_result;
    } bsd_result_t;

endpackage

/* hdl/bsd_intf.sv */
// Stream and configuration interfaces of the BMP stream decoder.
interface bsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;
    logic       end_of_file;

    modport source (output valid, output file_byte, output end_of_file, input ready);
    modport sink   (input valid, input file_byte, input end_of_file, output ready);
endinterface

interface bsd_cfg_if;
    logic        valid;
    logic        ready;
    logic [14:0] max_dimension;

    modport source (output valid, output max_dimension, input ready);
    modport sink   (input valid, input max_dimension, output ready);
endinterface

interface bsd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [2:0]  error_code;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [14:0] out_row;
    logic [14:0] out_column;
    logic [14:0] image_width;
    logic [14:0] image_height;
    logic        last_result;

    modport source (
        output valid, output result_kind, output error_code, output red, output green,
        output blue, output out_row, output out_column, output image_width,
        output image_height, output last_result, input ready
    );
    modport sink (
        input valid, input result_kind, input error_code, input red, input green,
        input blue, input out_row, input out_column, input image_width,
        input image_height, input last_result, output ready
    );
endinterface

/* hdl/bsd_core.sv */
// Byte-at-a-time header capture, header check and pixel unpacking.
module bsd_core
    import bsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    bsd_in_if.sink      byte_stream,
    bsd_cfg_if.sink     cfg,
    input  logic        space_ok,
    output logic        res_valid,
    output bsd_result_t res
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_SKIP   = 2'd1;
    localparam logic [1:0] PH_PIXELS = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    localparam logic [31:0] HDR_LAST_BYTE = 32'd53;
    localparam logic [31:0] MIN_INFO_SIZE = 32'd40;
    localparam logic [32:0] FILE_HDR_SIZE = 33'd14;
    localparam logic [15:0] MAGIC_BM      = 16'h4D42;
    localparam logic [15:0] BPP_24        = 16'd24;
    localparam logic [15:0] BPP_32        = 16'd32;

    // Header field byte offsets
    localparam logic [5:0] OFS_PIXOFF = 6'd10;
    localparam logic [5:0] OFS_INFO   = 6'd14;
    localparam logic [5:0] OFS_WIDTH  = 6'd18;
    localparam logic [5:0] OFS_HEIGHT = 6'd22;
    localparam logic [5:0] OFS_PLANES = 6'd26;
    localparam logic [5:0] OFS_BPP    = 6'd28;
    localparam logic [5:0] OFS_COMP   = 6'd30;
    localparam logic [5:0] OFS_END    = 6'd34;

    logic [DIM_W-1:0] max_dim_reg;

    logic [1:0]             phase_reg, phase_next;
    logic [31:0]            byte_pos_reg, byte_pos_next;
    logic [ROW_BYTES_W-1:0] bir_reg, bir_next;
    logic [1:0]             sub_reg, sub_next;
    logic [DIM_W-1:0]       col_reg, col_next;
    logic [DIM_W-1:0]       src_row_reg, src_row_next;
    logic                   neg_height_reg, neg_height_next;

    logic [7:0] held_blue_reg, held_blue_next;
    logic [7:0] held_green_reg, held_green_next;

    logic [15:0] magic_reg;
    logic [31:0] pix_off_reg;
    logic [31:0] info_size_reg;
    logic [31:0] width_raw_reg;
    logic [31:0] height_raw_reg;
    logic [15:0] planes_reg;
    logic [15:0] bpp_reg;
    logic [31:0] comp_reg;

    logic [DIM_W-1:0]       width_reg, height_reg;
    logic [ROW_BYTES_W-1:0] data_len_reg, row_last_reg;
    logic                   ch4_reg;

    logic                   accept;
    logic [5:0]             pos_lo;
    logic [31:0]            height_mag;
    logic [2:0]             hdr_code;
    logic                   width_bad, height_bad;
    logic [ROW_BYTES_W-1:0] w_ext, dl_calc, row_round;
    logic                   ch4_calc;
    logic [1:0]             sub_last;
    logic [DIM_W:0]         src_plus1, col_plus1;

    assign accept            = byte_stream.valid & byte_stream.ready;
    assign byte_stream.ready = space_ok;
    assign cfg.ready         = 1'b1;
    assign pos_lo            = byte_pos_reg[5:0];

    // Header check, evaluated from the captured fields
    always_comb
    begin
        height_mag = height_raw_reg[31] ? (~height_raw_reg + 32'd1) : height_raw_reg;
        width_bad  = width_raw_reg[31] || (width_raw_reg == 32'd0) ||
                     (width_raw_reg > {17'd0, max_dim_reg});
        height_bad = (height_mag == 32'd0) || (height_mag > {17'd0, max_dim_reg});
        if (magic_reg != MAGIC_BM)
            hdr_code = ERR_BAD_MAGIC;
        else if (info_size_reg < MIN_INFO_SIZE)
            hdr_code = ERR_UNSUPPORTED;
        else if (planes_reg != 16'd1)
            hdr_code = ERR_UNSUPPORTED;
        else if (comp_reg != 32'd0)
            hdr_code = ERR_UNSUPPORTED;
        else if (bpp_reg != BPP_24 && bpp_reg != BPP_32)
            hdr_code = ERR_UNSUPPORTED;
        else if (width_bad || height_bad)
            hdr_code = ERR_BAD_DIMS;
        else if ({1'b0, pix_off_reg} < FILE_HDR_SIZE + {1'b0, info_size_reg})
            hdr_code = ERR_UNSUPPORTED;
        else
            hdr_code = ERR_NONE;

        // Row geometry, only meaningful once the header passed
        ch4_calc  = (bpp_reg == BPP_32);
        w_ext     = {2'd0, width_raw_reg[DIM_W-1:0]};
        dl_calc   = ch4_calc ? (w_ext << 2) : (w_ext + (w_ext << 1));
        row_round = (dl_calc + 17'd3) & ~17'd3;
    end

    assign sub_last  = ch4_reg ? 2'd3 : 2'd2;
    assign src_plus1 = {1'b0, src_row_reg} + 16'd1;
    assign col_plus1 = {1'b0, col_reg} + 16'd1;

    always_comb
    begin
        phase_next      = phase_reg;
        byte_pos_next   = byte_pos_reg;
        bir_next        = bir_reg;
        sub_next        = sub_reg;
        col_next        = col_reg;
        src_row_next    = src_row_reg;
        neg_height_next = neg_height_reg;
        held_blue_next  = held_blue_reg;
        held_green_next = held_green_reg;
        res_valid       = 1'b0;
        res             = '0;

        if (accept)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (byte_pos_reg == HDR_LAST_BYTE)
                    begin
                        res_valid = 1'b1;
                        if (hdr_code != ERR_NONE)
                        begin
                            res.result_kind = KIND_ERROR;
                            res.error_code  = hdr_code;
                            phase_next      = PH_DONE;
                        end
                        else
                        begin
                            neg_height_next  = height_raw_reg[31];
                            res.result_kind  = KIND_HEADER;
                            res.image_width  = width_raw_reg[DIM_W-1:0];
                            res.image_height = height_mag[DIM_W-1:0];
                            phase_next       = PH_SKIP;
                        end
                    end
                end
                PH_SKIP, PH_PIXELS:
                begin
                    if (phase_reg == PH_PIXELS || byte_pos_reg >= pix_off_reg)
                    begin
                        phase_next = PH_PIXELS;
                        if (bir_reg < data_len_reg)
                        begin
                            case (sub_reg)
                                2'd0: held_blue_next = byte_stream.file_byte;
                                2'd1: held_green_next = byte_stream.file_byte;
                                2'd2:
                                begin
                                    res_valid       = 1'b1;
                                    res.result_kind = KIND_PIXEL;
                                    res.red         = byte_stream.file_byte;
                                    res.green       = held_green_reg;
                                    res.blue        = held_blue_reg;
                                    res.out_row     = neg_height_reg ? src_row_reg :
                                                      (height_reg - 15'd1 - src_row_reg);
                                    res.out_column  = col_reg;
                                    res.last_result = (src_plus1 == {1'b0, height_reg}) &&
                                                      (col_plus1 == {1'b0, width_reg});
                                end
                                default: ;  // alpha byte
                            endcase
                            if (sub_reg == sub_last)
                            begin
                                sub_next = 2'd0;
                                col_next = col_plus1[DIM_W-1:0];
                            end
                            else
                                sub_next = sub_reg + 2'd1;
                        end
                        if (bir_reg == row_last_reg)
                        begin
                            bir_next     = '0;
                            sub_next     = 2'd0;
                            col_next     = '0;
                            src_row_next = src_plus1[DIM_W-1:0];
                            if (src_plus1 == {1'b0, height_reg})
                                phase_next = PH_DONE;
                        end
                        else
                            bir_next = bir_reg + 17'd1;
                    end
                end
                default: ;
            endcase

            if (byte_pos_reg != 32'hFFFF_FFFF)
                byte_pos_next = byte_pos_reg + 32'd1;

            if (byte_stream.end_of_file)
            begin
                // early end overrides whatever this byte produced
                if (phase_next != PH_DONE)
                begin
                    res_valid       = 1'b1;
                    res             = '0;
                    res.result_kind = KIND_ERROR;
                    res.error_code  = ERR_TRUNCATED;
                end
                phase_next      = PH_HEADER;
                byte_pos_next   = '0;
                bir_next        = '0;
                sub_next        = 2'd0;
                col_next        = '0;
                src_row_next    = '0;
                neg_height_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_dim_reg    <= MAX_DIM_RESET;
            phase_reg      <= PH_HEADER;
            byte_pos_reg   <= '0;
            bir_reg        <= '0;
            sub_reg        <= 2'd0;
            col_reg        <= '0;
            src_row_reg    <= '0;
            neg_height_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                max_dim_reg <= cfg.max_dimension;
            phase_reg      <= phase_next;
            byte_pos_reg   <= byte_pos_next;
            bir_reg        <= bir_next;
            sub_reg        <= sub_next;
            col_reg        <= col_next;
            src_row_reg    <= src_row_next;
            neg_height_reg <= neg_height_next;
        end
    end

    // Header fields are fully rewritten by every file before they are checked
    always_ff @(posedge clk)
    begin
        held_blue_reg  <= held_blue_next;
        held_green_reg <= held_green_next;
        if (accept && phase_reg == PH_HEADER)
        begin
            if (pos_lo < 6'd2)
                magic_reg[{pos_lo[0], 3'b000} +: 8] <= byte_stream.file_byte;
            else if (pos_lo >= OFS_PIXOFF && pos_lo < OFS_INFO)
                pix_off_reg[{pos_lo[1:0] - OFS_PIXOFF[1:0], 3'b000} +: 8] <=
                    byte_stream.file_byte;
            else if (pos_lo >= OFS_INFO && pos_lo < OFS_WIDTH)
                info_size_reg[{pos_lo[1:0] - OFS_INFO[1:0], 3'b000} +: 8] <=
                    byte_stream.file_byte;
            else if (pos_lo >= OFS_WIDTH && pos_lo < OFS_HEIGHT)
                width_raw_reg[{pos_lo[1:0] - OFS_WIDTH[1:0], 3'b000} +: 8] <=
                    byte_stream.file_byte;
            else if (pos_lo >= OFS_HEIGHT && pos_lo < OFS_PLANES)
                height_raw_reg[{pos_lo[1:0] - OFS_HEIGHT[1:0], 3'b000} +: 8] <=
                    byte_stream.file_byte;
            else if (pos_lo >= OFS_PLANES && pos_lo < OFS_BPP)
                planes_reg[{pos_lo[0], 3'b000} +: 8] <= byte_stream.file_byte;
            else if (pos_lo >= OFS_BPP && pos_lo < OFS_COMP)
                bpp_reg[{pos_lo[0], 3'b000} +: 8] <= byte_stream.file_byte;
            else if (pos_lo >= OFS_COMP && pos_lo < OFS_END)
                comp_reg[{pos_lo[1:0] - OFS_COMP[1:0], 3'b000} +: 8] <= byte_stream.file_byte;

            if (byte_pos_reg == HDR_LAST_BYTE)
            begin
                width_reg    <= width_raw_reg[DIM_W-1:0];
                height_reg   <= height_mag[DIM_W-1:0];
                ch4_reg      <= ch4_calc;
                data_len_reg <= dl_calc;
                row_last_reg <= row_round - 17'd1;
            end
        end
    end

    a_eof_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && byte_stream.end_of_file |=> phase_reg == PH_HEADER && byte_pos_reg == 32'd0)
        else $error("file state not cleared after end of file");

    a_header_dims: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.result_kind == KIND_HEADER |->
            res.image_width != '0 && res.image_height != '0 &&
            res.image_width <= max_dim_reg && res.image_height <= max_dim_reg)
        else $error("header accepted with dimensions out of range");

    a_pixel_column: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.result_kind == KIND_PIXEL |->
            phase_reg != PH_HEADER && col_reg < width_reg && src_row_reg < height_reg)
        else $error("pixel emitted outside the image");

endmodule

/* hdl/bsd_out_buf.sv */
// Result register with one skid entry between decoder and result stream.
module bsd_out_buf
    import bsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  bsd_result_t res_data,
    output logic        space_ok,
    bsd_out_if.source   result_stream
);

    logic        out_valid_reg, skid_valid_reg;
    bsd_result_t out_data_reg, skid_data_reg;
    logic        pop;

    assign pop      = out_valid_reg & result_stream.ready;
    assign space_ok = ~skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_data_reg <= skid_data_reg;
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_data_reg <= res_data;
            else
                out_data_reg <= res_data;
        end
    end

    assign result_stream.valid        = out_valid_reg;
    assign result_stream.result_kind  = out_data_reg.result_kind;
    assign result_stream.error_code   = out_data_reg.error_code;
    assign result_stream.red          = out_data_reg.red;
    assign result_stream.green        = out_data_reg.green;
    assign result_stream.blue         = out_data_reg.blue;
    assign result_stream.out_row      = out_data_reg.out_row;
    assign result_stream.out_column   = out_data_reg.out_column;
    assign result_stream.image_width  = out_data_reg.image_width;
    assign result_stream.image_height = out_data_reg.image_height;
    assign result_stream.last_result  = out_data_reg.last_result;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without a head entry");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
        else $error("request pushed into a full buffer");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(push && out_valid_reg && !result_stream.ready))
        else $error("skid entry filled without a stalled head");

endmodule

/* hdl/bmp_stream_decoder.sv */
// Top level of the streaming BMP decoder.
// Results are registered in the output buffer before they appear on result_stream.
// Throughput: one file byte per cycle while not stalled, set by the single-pass decode between input and result.
// A stalled result stream fills one skid entry, then byte_stream.ready drops until it drains.
// Reset (rst_n low, asynchronous) clears the decode state and sets max_dimension to 20000.
// Every byte flagged end_of_file returns the file state to reset; max_dimension is kept.
module bmp_stream_decoder
    import bsd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    bsd_cfg_if.sink   cfg,
    bsd_in_if.sink    byte_stream,
    bsd_out_if.source result_stream
);

    logic        space_ok;
    logic        res_valid;
    bsd_result_t res;

    bsd_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_stream),
        .cfg         (cfg),
        .space_ok    (space_ok),
        .res_valid   (res_valid),
        .res         (res)
    );

    bsd_out_buf u_out_buf (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (res_valid),
        .res_data      (res),
        .space_ok      (space_ok),
        .result_stream (result_stream)
    );

endmodule
